// ===== rtl/spq_pkg.sv =====
// Shared types and constants of the sorted priority request queue.
// Item structs, operation codes, cell control struct and the group encoder.
// No dependencies.
`default_nettype none

package spq_pkg;

	localparam int POS_W      = 4;
	localparam int GROUP_SIZE = 2 ** POS_W;
	localparam int COUNT_W    = 5;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  requester_id;
		logic [15:0] priority_req;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] entry_count;
		logic               overflow;
	} out_item_t;

	typedef struct packed {
		logic insert;
		logic clear;
	} cell_ctrl_t;

	// lowest set bit of one group: {hit, index}
	function automatic logic [POS_W:0] first_one(input logic [GROUP_SIZE-1:0] v);
		logic [POS_W:0] res;
		res = '0;
		for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
			if (v[j]) begin
				res = {1'b1, POS_W'(j)};
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sorted_priority_request_queue.sv =====
// Top level of the sorted priority request queue: a row of spq_cell slots,
// the lookup encoder and the result register. Uses spq_pkg and spq_cell.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------
//   req     | req_valid/req_stall | req_item  (spq_pkg::in_item_t)
//   rsp     | rsp_valid/rsp_stall | rsp_item  (spq_pkg::out_item_t)
//
// Items are taken one at a time: the cells update at the accepting edge, then the
// id compare across all cells and the per-group first-hit encode are each
// registered, and the combinational group select feeds the result register.
// Reset empties the queue at once; no clearing pass is needed.
// A stalled result holds in the result register; a finished item waits in
// the last step until that register frees up, and req_stall stays high.
`default_nettype none

module sorted_priority_request_queue #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int ID_BITS       = 8,
	parameter int PRIORITY_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  spq_pkg::in_item_t    req_item,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output spq_pkg::out_item_t   rsp_item
);

	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int NG     = (QUEUE_DEPTH + spq_pkg::GROUP_SIZE - 1) / spq_pkg::GROUP_SIZE;
	localparam int HIT_W  = NG * spq_pkg::GROUP_SIZE;
	localparam int GSEL_W = (NG > 1) ? $clog2(NG) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MATCH = 2'd1;
	localparam logic [1:0] ST_GROUP = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [ID_BITS-1:0] key_id_q;
	logic               lookup_q;
	logic               ovf_q;

	logic                     accept;
	logic                     full;
	logic [ID_BITS-1:0]       id_in;
	logic [PRIORITY_BITS-1:0] pri_in;
	spq_pkg::cell_ctrl_t      ctrl;

	// cell row wiring
	logic [ID_BITS-1:0]       cell_id     [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0] cell_pri    [QUEUE_DEPTH];
	logic                     cell_valid  [QUEUE_DEPTH];
	logic                     cell_before [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]   cell_hit;

	// lookup stages
	logic [HIT_W-1:0]          hit_s1;
	logic [NG-1:0]             grp_hit_s2;
	logic [spq_pkg::POS_W-1:0] grp_pos_s2 [NG];

	// result register
	logic               out_valid_q;
	spq_pkg::out_item_t out_item_q;
	logic               out_load;
	spq_pkg::out_item_t result;

	assign id_in    = ID_BITS'(req_item.requester_id);
	assign pri_in   = PRIORITY_BITS'(req_item.priority_req);
	assign req_stall = (state_q != ST_IDLE);
	assign accept   = req_valid && !req_stall;
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));

	assign ctrl.insert = accept && (req_item.opcode == spq_pkg::OP_INSERT) && !full;
	assign ctrl.clear  = accept && (req_item.opcode == spq_pkg::OP_CLEAR);

	// the row of slots; slot 0 has an imaginary always-valid, never-yielding
	// neighbour on its left, so it takes the new entry when it yields
	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		logic [ID_BITS-1:0]       l_id;
		logic [PRIORITY_BITS-1:0] l_pri;
		logic                     l_valid;
		logic                     l_before;

		if (k == 0) begin : g_head
			assign l_id     = id_in;
			assign l_pri    = pri_in;
			assign l_valid  = 1'b1;
			assign l_before = 1'b0;
		end else begin : g_body
			assign l_id     = cell_id[k-1];
			assign l_pri    = cell_pri[k-1];
			assign l_valid  = cell_valid[k-1];
			assign l_before = cell_before[k-1];
		end

		spq_cell #(
			.ID_BITS       (ID_BITS),
			.PRIORITY_BITS (PRIORITY_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_id      (id_in),
			.new_pri     (pri_in),
			.key_id      (key_id_q),
			.left_id     (l_id),
			.left_pri    (l_pri),
			.left_valid  (l_valid),
			.left_ahead  (l_before),
			.cell_id     (cell_id[k]),
			.cell_pri    (cell_pri[k]),
			.cell_valid  (cell_valid[k]),
			.new_ahead   (cell_before[k]),
			.hit         (cell_hit[k])
		);
	end

	// sequencer: advance one step a cycle, wait in ST_IDLE for an accepted item and
	// hold in ST_DONE while the result register is occupied and stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: state_q <= ST_GROUP;
				ST_GROUP: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ctrl.clear) begin
				count_q <= '0;
			end else if (ctrl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// per-item context: the key to look up, whether a lookup applies at all,
	// and whether an insert was dropped
	always_ff @(posedge clk) begin
		if (accept) begin
			key_id_q <= id_in;
			lookup_q <= (req_item.opcode == spq_pkg::OP_INSERT) ||
			            (req_item.opcode == spq_pkg::OP_QUERY);
			ovf_q    <= (req_item.opcode == spq_pkg::OP_INSERT) && full;
		end
	end

	// compare all slots against the key, then encode each group of slots
	always_ff @(posedge clk) begin
		if (state_q == ST_MATCH) begin
			hit_s1 <= HIT_W'(cell_hit);
		end
	end

	for (genvar g = 0; g < NG; g++) begin : g_grp
		logic [spq_pkg::POS_W:0] enc;
		assign enc = spq_pkg::first_one(
			hit_s1[g*spq_pkg::GROUP_SIZE +: spq_pkg::GROUP_SIZE]);
		always_ff @(posedge clk) begin
			if (state_q == ST_GROUP) begin
				grp_hit_s2[g] <= enc[spq_pkg::POS_W];
				grp_pos_s2[g] <= enc[spq_pkg::POS_W-1:0];
			end
		end
	end

	// pick the first group with a hit; the position field keeps only the low
	// bits, which is the index inside the group
	always_comb begin
		logic [GSEL_W-1:0] sel;
		logic              any;
		sel = '0;
		any = 1'b0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_hit_s2[g]) begin
				sel = GSEL_W'(g);
				any = 1'b1;
			end
		end
		result.found       = lookup_q && any;
		result.position    = (lookup_q && any) ? grp_pos_s2[sel] : '0;
		result.entry_count = spq_pkg::COUNT_W'(count_q);
		result.overflow    = ovf_q;
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q <= result;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_item_q;

endmodule

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue: holds an entry, decides on insert whether to
// keep it, take the new entry or take the left neighbour's. Uses spq_pkg.
`default_nettype none

module spq_cell #(
	parameter int ID_BITS       = 8,
	parameter int PRIORITY_BITS = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  spq_pkg::cell_ctrl_t           ctrl,
	input  wire  [ID_BITS-1:0]            new_id,
	input  wire  [PRIORITY_BITS-1:0]      new_pri,
	input  wire  [ID_BITS-1:0]            key_id,
	input  wire  [ID_BITS-1:0]            left_id,
	input  wire  [PRIORITY_BITS-1:0]      left_pri,
	input  wire                           left_valid,
	input  wire                           left_ahead,
	output logic [ID_BITS-1:0]            cell_id,
	output logic [PRIORITY_BITS-1:0]      cell_pri,
	output logic                          cell_valid,
	output logic                          new_ahead,
	output logic                          hit
);

	logic [ID_BITS-1:0]       id_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic                     valid_q;

	// new entry orders ahead of this slot (an empty slot always yields)
	assign new_ahead = !valid_q || (new_pri < pri_q) ||
	                   ((new_pri == pri_q) && (new_id < id_q));
	assign hit       = valid_q && (id_q == key_id);

	assign cell_id    = id_q;
	assign cell_pri   = pri_q;
	assign cell_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert && new_ahead) begin
			valid_q <= valid_q | left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert && new_ahead) begin
			if (left_ahead) begin
				// shift right: take neighbour's entry
				id_q  <= left_id;
				pri_q <= left_pri;
			end else begin
				id_q  <= new_id;
				pri_q <= new_pri;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/spq_checker.sv =====
// Port-level checks for the sorted priority request queue, bound to the top.
// Uses spq_pkg types; sees only the top level's ports.
`default_nettype none

module spq_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 req_valid,
	input wire                 req_stall,
	input spq_pkg::in_item_t   req_item,
	input wire                 rsp_valid,
	input wire                 rsp_stall,
	input spq_pkg::out_item_t  rsp_item
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
		else $error("stalled result dropped or changed");

	// an accepted item blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second item taken while one is at work");

	// a miss reports position zero
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_item.found |-> rsp_item.position == '0)
		else $error("non-zero position without a hit");

	// a dropped insert only happens on a full queue
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.overflow |->
			rsp_item.entry_count == spq_pkg::COUNT_W'(QUEUE_DEPTH))
		else $error("overflow reported below full");

endmodule

bind sorted_priority_request_queue spq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_item  (req_item),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_item  (rsp_item)
);

`default_nettype wire

// ===== bench/queue_checker.sv =====
// Checker for the sorted priority request queue: watches both channels,
// keeps its own sorted copy of the queue and compares every result field by field.
// Depends on spq_pkg for the item structs and operation codes.
`default_nettype none

module queue_checker #(
	parameter int DEPTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	input  wire                req_stall,
	input  spq_pkg::in_item_t  req_item,
	input  wire                rsp_valid,
	input  wire                rsp_stall,
	input  spq_pkg::out_item_t rsp_item,
	output int                 fault_count,
	output int                 replies_outstanding
);

	localparam int DUE_DEPTH = 8;

	logic [7:0]         slot_ids  [DEPTH];
	logic [15:0]        slot_pris [DEPTH];
	int                 held;
	spq_pkg::out_item_t replies_due [DUE_DEPTH];
	logic [2:0]         due_rd;
	logic [2:0]         due_wr;
	int                 due_cnt;
	spq_pkg::out_item_t want;

	initial begin
		fault_count = 0;
		held = 0;
		due_rd = '0;
		due_wr = '0;
		due_cnt = 0;
		replies_outstanding = 0;
	end

	task automatic report_fault(input string msg);
		fault_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// {hit, index of the first slot holding id}
	function automatic logic [4:0] locate_id(input logic [7:0] id);
		logic [4:0] res;
		int k;
		res = '0;
		for (k = held - 1; k >= 0; k--) begin
			if (slot_ids[k] == id) begin
				res = {1'b1, 4'(k)};
			end
		end
		return res;
	endfunction

	function automatic spq_pkg::out_item_t apply_queue_op(input spq_pkg::in_item_t it);
		spq_pkg::out_item_t r;
		logic [4:0] hit;
		int slot;
		int k;
		r = '0;
		case (it.opcode)
			spq_pkg::OP_INSERT: begin
				if (held >= DEPTH) begin
					r.overflow = 1'b1;
				end else begin
					slot = held;
					for (k = held - 1; k >= 0; k--) begin
						if (it.priority_req < slot_pris[k] ||
						    (it.priority_req == slot_pris[k] &&
						     it.requester_id < slot_ids[k])) begin
							slot = k;
						end
					end
					for (k = held; k > slot; k--) begin
						slot_ids[k]  = slot_ids[k-1];
						slot_pris[k] = slot_pris[k-1];
					end
					slot_ids[slot]  = it.requester_id;
					slot_pris[slot] = it.priority_req;
					held++;
				end
				hit = locate_id(it.requester_id);
				r.found    = hit[4];
				r.position = hit[3:0];
			end
			spq_pkg::OP_QUERY: begin
				hit = locate_id(it.requester_id);
				r.found    = hit[4];
				r.position = hit[3:0];
			end
			spq_pkg::OP_CLEAR: begin
				held = 0;
			end
			default: begin
			end
		endcase
		r.entry_count = 5'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			due_rd = '0;
			due_wr = '0;
			due_cnt = 0;
			replies_outstanding <= 0;
		end else begin
			// retire results before predicting, so a stray result is never matched
			// against an item accepted at the same edge
			if (rsp_valid && !rsp_stall) begin
				if (due_cnt == 0) begin
					report_fault($sformatf(
						"unexpected result found=%0d position=%0d count=%0d overflow=%0d",
						rsp_item.found, rsp_item.position, rsp_item.entry_count,
						rsp_item.overflow));
				end else begin
					want = replies_due[due_rd];
					due_rd = due_rd + 3'd1;
					due_cnt--;
					if (rsp_item.found !== want.found)
						report_fault($sformatf("found got %0d want %0d",
							rsp_item.found, want.found));
					if (rsp_item.position !== want.position)
						report_fault($sformatf("position got %0d want %0d",
							rsp_item.position, want.position));
					if (rsp_item.entry_count !== want.entry_count)
						report_fault($sformatf("entry_count got %0d want %0d",
							rsp_item.entry_count, want.entry_count));
					if (rsp_item.overflow !== want.overflow)
						report_fault($sformatf("overflow got %0d want %0d",
							rsp_item.overflow, want.overflow));
				end
			end
			if (req_valid && !req_stall) begin
				if (due_cnt == DUE_DEPTH) begin
					report_fault("too many results outstanding");
				end else begin
					replies_due[due_wr] = apply_queue_op(req_item);
					due_wr = due_wr + 3'd1;
					due_cnt++;
				end
			end
			replies_outstanding <= due_cnt;
		end
	end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Top of the bench for the sorted priority request queue: clock, reset,
// directed and random request items, stall on the result side and the verdict.
// Depends on spq_pkg, sorted_priority_request_queue and queue_checker.
`default_nettype none

module testbench;

	// opcode three is unused by the block: a no-op that still answers
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam int RANDOM_ITEMS = 1130;
	localparam int QUIET_TAIL   = 150;
	localparam int LIMIT_CYCLES = 250000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	spq_pkg::in_item_t  req_item;
	logic               rsp_valid;
	logic               rsp_stall;
	spq_pkg::out_item_t rsp_item;
	int                 fault_count;
	int                 replies_outstanding;
	bit                 idling = 1'b1;

	always #6 clk = ~clk;

	sorted_priority_request_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	queue_checker #(.DEPTH(16)) watch (
		.clk                 (clk),
		.arst_n              (arst_n),
		.req_valid           (req_valid),
		.req_stall           (req_stall),
		.req_item            (req_item),
		.rsp_valid           (rsp_valid),
		.rsp_stall           (rsp_stall),
		.rsp_item            (rsp_item),
		.fault_count         (fault_count),
		.replies_outstanding (replies_outstanding)
	);

	// Hard stop: far beyond the slowest correct run (each item's pass through the
	// block plus the longest gap and stall bursts on every item, plus the drain pauses).
	initial begin
		#(LIMIT_CYCLES * 12);
		$display("== FAIL ==");
		$finish;
	end

	// Result side: stall in random bursts while idling is on.
	// Every change lands on a rising edge, so the block samples the old value.
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (idling && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Offer one request item and hold it until the block takes it. Valid is
	// only lowered when a gap is wanted, so back-to-back items keep it high.
	task automatic offer(input logic [1:0] op, input logic [7:0] id,
	                     input logic [15:0] pri);
		spq_pkg::in_item_t it;
		it.opcode       = op;
		it.requester_id = id;
		it.priority_req = pri;
		if (idling && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= it;
		do @(posedge clk); while (req_stall);
	endtask

	// Hold off the sender until every outstanding result has come back.
	// The first edge lets the checker count the item just accepted.
	task automatic drain_queue;
		req_valid <= 1'b0;
		@(posedge clk);
		while (replies_outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int          sent;
		int          next_drain;
		int          run_len;
		int          roll;
		int          waited;
		bit          narrow_ids;
		bit          narrow_pris;
		logic [7:0]  id_base;
		logic [15:0] pri_base;
		logic [7:0]  id;
		logic [15:0] pri;
		logic [1:0]  op;

		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_item  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue first - lookup, clear and the unused opcode.
		offer(spq_pkg::OP_QUERY, 8'd0, 16'd0);
		offer(spq_pkg::OP_CLEAR, 8'hff, 16'hffff);
		offer(OP_NONE, 8'h5a, 16'ha5a5);
		// Extremes of id and priority; the lowest priority lands in front.
		offer(spq_pkg::OP_INSERT, 8'hff, 16'hffff);
		offer(spq_pkg::OP_INSERT, 8'h00, 16'h0000);
		// Equal priorities order by id; an exact duplicate lands behind its twin.
		offer(spq_pkg::OP_INSERT, 8'd7, 16'd100);
		offer(spq_pkg::OP_INSERT, 8'd3, 16'd100);
		offer(spq_pkg::OP_INSERT, 8'd7, 16'd100);
		offer(spq_pkg::OP_INSERT, 8'h00, 16'hffff);
		// Lookups: a duplicated id reports its first slot; an absent id reports zero.
		offer(spq_pkg::OP_QUERY, 8'd7, 16'd0);
		offer(spq_pkg::OP_QUERY, 8'd200, 16'd0);
		offer(OP_NONE, 8'd7, 16'd7);
		// Fill to the brim, then overflow with a present and an absent id.
		for (int k = 0; k < 10; k++) begin
			offer(spq_pkg::OP_INSERT, 8'(100 + k), 16'($urandom));
		end
		offer(spq_pkg::OP_INSERT, 8'hff, 16'd1);
		offer(spq_pkg::OP_INSERT, 8'd42, 16'd1);
		offer(spq_pkg::OP_CLEAR, 8'd0, 16'd0);
		drain_queue();

		// Random: runs that mostly start from an empty queue, with ids and
		// priorities drawn from a narrow window (so duplicates, ties and hits
		// are common) or from the whole range.
		sent = 0;
		next_drain = 250;
		while (sent < RANDOM_ITEMS) begin
			run_len     = $urandom_range(3, 40);
			narrow_ids  = $urandom_range(0, 2) != 0;
			narrow_pris = $urandom_range(0, 1) != 0;
			id_base     = 8'($urandom);
			pri_base    = 16'($urandom);
			if ($urandom_range(0, 3) != 0) begin
				offer(spq_pkg::OP_CLEAR, 8'($urandom), 16'($urandom));
				sent++;
			end
			for (int j = 0; j < run_len; j++) begin
				// switch idling off for the tail of the random phase
				if (sent >= RANDOM_ITEMS - QUIET_TAIL) idling = 1'b0;
				roll = $urandom_range(0, 99);
				id   = narrow_ids  ? 8'(id_base + $urandom_range(0, 7))   : 8'($urandom);
				pri  = narrow_pris ? 16'(pri_base + $urandom_range(0, 3)) : 16'($urandom);
				if (roll < 55)      op = spq_pkg::OP_INSERT;
				else if (roll < 95) op = spq_pkg::OP_QUERY;
				else if (roll < 97) op = spq_pkg::OP_CLEAR;
				else                op = OP_NONE;
				offer(op, id, pri);
				sent++;
			end
			if (sent >= next_drain) begin
				drain_queue();
				next_drain += 250;
			end
		end

		// Drop valid, wait out the results with a bound, then idle on so that
		// the pipeline can show any stray result.
		idling = 1'b0;
		req_valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (replies_outstanding != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (12) @(posedge clk);
		if (fault_count == 0 && replies_outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
